// ===== rtl/core/row_window_density_peak_unit_assert.svh =====
// Assertion macros for the row window density peak unit.
`ifndef ROW_WINDOW_DENSITY_PEAK_UNIT_ASSERT_SVH
`define ROW_WINDOW_DENSITY_PEAK_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RWDP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RWDP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RWDP_ASSERT(label, prop, msg)
`define RWDP_ASSERT_RST(label, prop, msg)
`endif

`endif

// ===== rtl/core/rwdp_pkg.sv =====
// Types and constants shared by the row window density peak unit.
`default_nettype none
package rwdp_pkg;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int CNT_W     = 7;
  localparam int LEN_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RESET      = 7'd25;
  localparam logic [PIX_W-1:0] PIXEL_THRESHOLD_RESET = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN      = 1'b0,
    REG_PIXEL_THRESHOLD = 1'b1
  } rwdp_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_start;
  } rwdp_pixel_t;

  typedef struct packed {
    logic [CNT_W-1:0] left_peak_count;
    logic [COL_W-1:0] left_peak_start;
    logic [CNT_W-1:0] right_peak_count;
    logic [COL_W-1:0] right_peak_start;
  } rwdp_peak_t;

  typedef struct packed {
    rwdp_reg_t        index;
    logic [PIX_W-1:0] value;
  } rwdp_cfg_t;

  // per-column control carried down the pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             eligible;
    logic             is_left;
    logic [COL_W-1:0] start_col;
  } rwdp_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/core/rwdp_stream_if.sv =====
// Valid/ready channel interface with a typed word.
`default_nettype none
interface rwdp_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rwdp_front.sv =====
// Column tracking, binarize, history shift and window mask (stage 1).
`default_nettype none
module rwdp_front #(
  parameter int ROW_WIDTH  = 640,
  parameter int HALF_WIDTH = 320,
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      accept,
  input  wire logic [rwdp_pkg::PIX_W-1:0] pixel,
  input  wire logic                      row_start,
  input  wire logic [rwdp_pkg::LEN_W-1:0] window_len,
  input  wire logic [rwdp_pkg::PIX_W-1:0] pixel_threshold,
  output logic                           s1_valid,
  output rwdp_pkg::rwdp_ctrl_t           s1_ctrl,
  output logic [WINDOW_MAX-1:0]          s1_bits
);
  import rwdp_pkg::*;

  localparam logic [COL_W-1:0] HALF_COL = COL_W'(HALF_WIDTH);
  localparam logic [COL_W:0]   HALF_EXT = (COL_W + 1)'(HALF_WIDTH);
  localparam logic [COL_W:0]   ROW_EXT  = (COL_W + 1)'(ROW_WIDTH);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(WINDOW_MAX);

  logic [COL_W-1:0]      col;
  logic [WINDOW_MAX-1:0] hist;

  logic [COL_W-1:0]      c;
  logic [COL_W:0]        c1;
  logic [COL_W:0]        half_lo;
  logic [LEN_W-1:0]      len;
  logic                  set_bit;
  logic [WINDOW_MAX-1:0] hist_next;
  logic [WINDOW_MAX-1:0] mask;
  rwdp_ctrl_t            ctrl;

  always_comb begin
    c = (row_start || col == '0) ? '0 : col;
    c1 = {1'b0, c} + 1'b1;
    if (window_len == '0) begin
      len = LEN_W'(1);
    end else if (window_len > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = window_len;
    end
    set_bit = pixel > pixel_threshold;
    if (c == '0 || c == HALF_COL) begin
      hist_next = WINDOW_MAX'(set_bit);
    end else begin
      hist_next = (hist << 1) | WINDOW_MAX'(set_bit);
    end
    for (int i = 0; i < WINDOW_MAX; i++) begin
      mask[i] = LEN_W'(i) < len;
    end
    half_lo = (c < HALF_COL) ? '0 : HALF_EXT;
    ctrl.first     = c == '0;
    ctrl.last      = c1 >= ROW_EXT;
    ctrl.eligible  = c1 >= half_lo + (COL_W + 1)'(len);
    ctrl.is_left   = c < HALF_COL;
    ctrl.start_col = COL_W'(c1 - (COL_W + 1)'(len));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      hist     <= '0;
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
      if (accept) begin
        col  <= ctrl.last ? '0 : c1[COL_W-1:0];
        hist <= hist_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && accept) begin
      s1_ctrl <= ctrl;
      s1_bits <= hist_next & mask;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rwdp_popcount.sv =====
// Two-stage set-pixel count: byte partials, then their sum.
`default_nettype none
module rwdp_popcount #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      s1_valid,
  input  wire rwdp_pkg::rwdp_ctrl_t      s1_ctrl,
  input  wire logic [WINDOW_MAX-1:0]     s1_bits,
  output logic                           s3_valid,
  output rwdp_pkg::rwdp_ctrl_t           s3_ctrl,
  output logic [rwdp_pkg::CNT_W-1:0]     s3_count
);
  import rwdp_pkg::*;

  localparam int NGRP = (WINDOW_MAX + 7) / 8;

  logic [NGRP*8-1:0] padded;
  logic [3:0]        part_c [NGRP];
  logic [3:0]        s2_part [NGRP];
  logic              s2_valid;
  rwdp_ctrl_t        s2_ctrl;
  logic [CNT_W-1:0]  total;

  always_comb begin
    padded = (NGRP * 8)'(s1_bits);
    for (int g = 0; g < NGRP; g++) begin
      part_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        part_c[g] = part_c[g] + 4'(padded[g*8+b]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < NGRP; g++) begin
      total = total + CNT_W'(s2_part[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctrl  <= s1_ctrl;
      s2_part  <= part_c;
      s3_ctrl  <= s2_ctrl;
      s3_count <= total;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/rwdp_peak.sv =====
// Per-half peak tracking and the result register.
`default_nettype none
module rwdp_peak #(
  parameter int HALF_WIDTH = 320
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      adv,
  input  wire logic                      s3_valid,
  input  wire rwdp_pkg::rwdp_ctrl_t      s3_ctrl,
  input  wire logic [rwdp_pkg::CNT_W-1:0] s3_count,
  input  wire logic                      out_ready,
  output logic                           out_valid,
  output rwdp_pkg::rwdp_peak_t           out_data
);
  import rwdp_pkg::*;

  localparam logic [COL_W-1:0] HALF_COL = COL_W'(HALF_WIDTH);

  rwdp_peak_t best;
  rwdp_peak_t base;
  rwdp_peak_t best_next;
  logic       take;

  always_comb begin
    if (s3_ctrl.first) begin
      base.left_peak_count  = '0;
      base.left_peak_start  = '0;
      base.right_peak_count = '0;
      base.right_peak_start = HALF_COL;
    end else begin
      base = best;
    end
    best_next = base;
    if (s3_ctrl.eligible) begin
      if (s3_ctrl.is_left) begin
        if (s3_count > base.left_peak_count) begin
          best_next.left_peak_count = s3_count;
          best_next.left_peak_start = s3_ctrl.start_col;
        end
      end else if (s3_count > base.right_peak_count) begin
        best_next.right_peak_count = s3_count;
        best_next.right_peak_start = s3_ctrl.start_col;
      end
    end
    take = adv && s3_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        best <= best_next;
      end
      if (take && s3_ctrl.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && s3_ctrl.last) begin
      out_data <= best_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/row_window_density_peak_unit.sv =====
// Top level of the row window density peak unit.
//
//   channel | dir | word          | accepted when
//   --------+-----+---------------+---------------------------
//   pix     | in  | rwdp_pixel_t  | pix.valid && pix.ready
//   peak    | out | rwdp_peak_t   | peak.valid && peak.ready
//   cfg     | in  | rwdp_cfg_t    | cfg.valid && cfg.ready
//
// One pixel word per cycle unless pix stalls; the last column's peak update loads the result.
// Stages: history/mask, byte popcounts, count sum, peak update into result reg.
// Synchronous reset clears column, history, peaks and registers to defaults.
// pix stalls only when a second result reaches the full result register.
// cfg is always ready.
`default_nettype none
`include "row_window_density_peak_unit_assert.svh"
module row_window_density_peak_unit #(
  parameter int ROW_WIDTH  = 640,
  parameter int HALF_WIDTH = 320,
  parameter int WINDOW_MAX = 64
) (
  input wire logic     clk,
  input wire logic     rst,
  rwdp_stream_if.sink   pix,
  rwdp_stream_if.source peak,
  rwdp_stream_if.sink   cfg
);
  import rwdp_pkg::*;

  logic [LEN_W-1:0] window_len;
  logic [PIX_W-1:0] pixel_threshold;

  logic             adv;
  logic             accept;
  logic             s1_valid;
  rwdp_ctrl_t       s1_ctrl;
  logic [WINDOW_MAX-1:0] s1_bits;
  logic             s3_valid;
  rwdp_ctrl_t       s3_ctrl;
  logic [CNT_W-1:0] s3_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len      <= WINDOW_LEN_RESET;
      pixel_threshold <= PIXEL_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_WINDOW_LEN:      window_len      <= cfg.data.value[LEN_W-1:0];
        REG_PIXEL_THRESHOLD: pixel_threshold <= cfg.data.value;
        default: ;
      endcase
    end
  end

  assign adv       = !(s3_valid && s3_ctrl.last && peak.valid && !peak.ready);
  assign pix.ready = adv;
  assign accept    = pix.valid && adv;

  rwdp_front #(
    .ROW_WIDTH  (ROW_WIDTH),
    .HALF_WIDTH (HALF_WIDTH),
    .WINDOW_MAX (WINDOW_MAX)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .accept          (accept),
    .pixel           (pix.data.pixel),
    .row_start       (pix.data.row_start),
    .window_len      (window_len),
    .pixel_threshold (pixel_threshold),
    .s1_valid        (s1_valid),
    .s1_ctrl         (s1_ctrl),
    .s1_bits         (s1_bits)
  );

  rwdp_popcount #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_popcount (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_ctrl  (s1_ctrl),
    .s1_bits  (s1_bits),
    .s3_valid (s3_valid),
    .s3_ctrl  (s3_ctrl),
    .s3_count (s3_count)
  );

  rwdp_peak #(
    .HALF_WIDTH (HALF_WIDTH)
  ) u_peak (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .s3_valid  (s3_valid),
    .s3_ctrl   (s3_ctrl),
    .s3_count  (s3_count),
    .out_ready (peak.ready),
    .out_valid (peak.valid),
    .out_data  (peak.data)
  );

  `RWDP_ASSERT(a_stall_needs_result, !pix.ready |-> peak.valid, "pix stalled with no result held")
  `RWDP_ASSERT(a_count_range, peak.valid |-> (peak.data.left_peak_count <= CNT_W'(WINDOW_MAX) && peak.data.right_peak_count <= CNT_W'(WINDOW_MAX)), "peak count above window max")
  `RWDP_ASSERT_RST(a_reset_clears, rst |=> !peak.valid, "result valid after reset")
endmodule
`default_nettype wire
